>>> hdl/assert_macros.svh
// assertion macros shared by the burn cell update rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DBC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dbc_pkg.sv
// types and constants for the burn cell update pipeline
// no dependencies; imported by every module of the block
package dbc_pkg;

   localparam int TEMP_W      = 32;
   localparam int REG_W       = 31;
   localparam int FRAC_W      = 16;
   localparam int S4_W        = 38;
   localparam int MAG_W       = 37;
   localparam int MAG_LO_W    = 19;
   localparam int MAG_HI_W    = MAG_W - MAG_LO_W;
   localparam int LAP_SHIFT   = 18;
   localparam int LO_PROD_W   = MAG_LO_W + REG_W;
   localparam int HI_PROD_W   = MAG_HI_W + REG_W;
   localparam int LAP_SUM_W   = HI_PROD_W + MAG_LO_W;
   localparam int LAP_Q_W     = LAP_SUM_W - LAP_SHIFT;
   localparam int SRC_PROD_W  = REG_W + REG_W;
   localparam int SRC_Q_W     = SRC_PROD_W - FRAC_W;
   localparam int RATE_MAG_W  = TEMP_W;
   localparam int STEP_PROD_W = RATE_MAG_W + REG_W;
   localparam int DELTA_W     = STEP_PROD_W - FRAC_W;
   localparam int NT_SUM_W    = DELTA_W + 2;

   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_DATA_W  = 384;
   localparam int RSP_DATA_W  = 104;

   localparam logic [CSR_ADDR_W-1:0] CSR_IGNITION_TEMP     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BURN_DURATION     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_BURN_DURATION = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_SPACING_SQ    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP         = 3'd4;

   localparam logic [REG_W-1:0] IGNITION_TEMP_RST     = 31'd65536;
   localparam logic [REG_W-1:0] BURN_DURATION_RST     = 31'd65536;
   localparam logic [REG_W-1:0] INV_BURN_DURATION_RST = 31'd65536;
   localparam logic [REG_W-1:0] INV_SPACING_SQ_RST    = 31'd65536;
   localparam logic [REG_W-1:0] TIME_STEP_RST         = 31'd655;

   localparam logic [TEMP_W-1:0] DEPLETED_MARK = 32'hFFFF_0000;
   localparam logic [TEMP_W-1:0] TEMP_CEIL     = 32'h7FFF_FFFF;
   localparam logic [TEMP_W-1:0] TEMP_FLOOR    = 32'h8000_0000;
   localparam logic [REG_W-1:0]  SRC_MAX       = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [REG_W-1:0] ignition_temp;
      logic [REG_W-1:0] burn_duration;
      logic [REG_W-1:0] inv_burn_duration;
      logic [REG_W-1:0] inv_spacing_sq;
      logic [REG_W-1:0] time_step;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0] centre_temp;
      logic [TEMP_W-1:0] north_temp;
      logic [TEMP_W-1:0] south_temp;
      logic [TEMP_W-1:0] west_temp;
      logic [TEMP_W-1:0] east_temp;
      logic [TEMP_W-1:0] northwest_temp;
      logic [TEMP_W-1:0] northeast_temp;
      logic [TEMP_W-1:0] southwest_temp;
      logic [TEMP_W-1:0] southeast_temp;
      logic [TEMP_W-1:0] burn_deadline;
      logic [REG_W-1:0]  source_strength;
      logic [REG_W-1:0]  current_time;
   } cell_type;

   typedef struct packed {
      logic              s4_neg;
      logic [MAG_W-1:0]  s4_mag;
      logic [TEMP_W-1:0] centre_temp;
      logic [TEMP_W-1:0] new_deadline;
      logic              source_on;
      logic [REG_W-1:0]  source_strength;
   } front_type;

   typedef struct packed {
      logic                  lap_neg;
      logic [LO_PROD_W-1:0]  lap_lo_prod;
      logic [HI_PROD_W-1:0]  lap_hi_prod;
      logic [SRC_PROD_W-1:0] src_prod;
      logic [TEMP_W-1:0]     centre_temp;
      logic [TEMP_W-1:0]     new_deadline;
      logic                  source_on;
   } product_type;

   typedef struct packed {
      logic [TEMP_W-1:0] laplacian;
      logic [REG_W-1:0]  source_term;
      logic [TEMP_W-1:0] centre_temp;
      logic [TEMP_W-1:0] new_deadline;
      logic              source_on;
   } scaled_type;

   typedef struct packed {
      logic                  rate_neg;
      logic [RATE_MAG_W-1:0] rate_mag;
      logic [TEMP_W-1:0]     laplacian;
      logic [TEMP_W-1:0]     centre_temp;
      logic [TEMP_W-1:0]     new_deadline;
      logic                  source_on;
   } rate_type;

   typedef struct packed {
      logic                   rate_neg;
      logic [STEP_PROD_W-1:0] step_prod;
      logic [TEMP_W-1:0]      laplacian;
      logic [TEMP_W-1:0]      centre_temp;
      logic [TEMP_W-1:0]      new_deadline;
      logic                   source_on;
   } step_type;

   typedef struct packed {
      logic [TEMP_W-1:0] new_temp;
      logic [TEMP_W-1:0] laplacian;
      logic [TEMP_W-1:0] new_deadline;
      logic              source_on;
   } result_type;

endpackage

>>> hdl/dbc_front.sv
// stage one: nine-point stencil sum and ignition rule
// depends on dbc_pkg
module dbc_front
   import dbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  cell_type  in_cell,
   output logic      out_valid,
   input  logic      out_ready,
   output front_type out_stage
);

   logic                   valid_ff, valid_in;
   front_type              stage_ff, stage_in;
   logic signed [S4_W-1:0] c_ext, edges, corners, s4;
   logic [TEMP_W-1:0]      dl_sum;
   logic                   c_ge_ign, dl_gt_now;

   function automatic logic signed [S4_W-1:0] sx(input logic [TEMP_W-1:0] v);
      return {{(S4_W-TEMP_W){v[TEMP_W-1]}}, v};
   endfunction

   always_comb begin
      c_ext   = sx(in_cell.centre_temp);
      edges   = sx(in_cell.north_temp) + sx(in_cell.south_temp)
              + sx(in_cell.west_temp) + sx(in_cell.east_temp);
      corners = sx(in_cell.northwest_temp) + sx(in_cell.northeast_temp)
              + sx(in_cell.southwest_temp) + sx(in_cell.southeast_temp);
      s4      = (edges <<< 1) + corners - ((c_ext <<< 3) + (c_ext <<< 2));

      stage_in.s4_neg          = s4[S4_W-1];
      stage_in.s4_mag          = s4[S4_W-1] ? MAG_W'(-s4) : MAG_W'(s4);
      stage_in.centre_temp     = in_cell.centre_temp;
      stage_in.source_strength = in_cell.source_strength;

      c_ge_ign  = $signed(in_cell.centre_temp) >= $signed({1'b0, cfg.ignition_temp});
      dl_gt_now = $signed(in_cell.burn_deadline) > $signed({1'b0, in_cell.current_time});
      dl_sum    = {1'b0, in_cell.current_time} + {1'b0, cfg.burn_duration};

      if (in_cell.burn_deadline[TEMP_W-1]) begin
         stage_in.new_deadline = DEPLETED_MARK;
         stage_in.source_on    = 1'b0;
      end else if (in_cell.burn_deadline == '0) begin
         if (c_ge_ign) begin
            stage_in.new_deadline = dl_sum[TEMP_W-1] ? TEMP_CEIL : dl_sum;
            stage_in.source_on    = 1'b1;
         end else begin
            stage_in.new_deadline = '0;
            stage_in.source_on    = 1'b0;
         end
      end else if (dl_gt_now) begin
         stage_in.new_deadline = in_cell.burn_deadline;
         stage_in.source_on    = 1'b1;
      end else begin
         stage_in.new_deadline = DEPLETED_MARK;
         stage_in.source_on    = 1'b0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

>>> hdl/dbc_scale.sv
// stages two and three: laplacian and source products, then rounding and saturation
// depends on dbc_pkg
module dbc_scale
   import dbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  front_type  in_stage,
   output logic       out_valid,
   input  logic       out_ready,
   output scaled_type out_stage
);

   logic                 prod_valid_ff, prod_valid_in, prod_ready;
   product_type          prod_ff, prod_in;
   logic                 scaled_valid_ff, scaled_valid_in, scaled_ready;
   scaled_type           scaled_ff, scaled_in;
   logic [MAG_LO_W-1:0]  mag_lo;
   logic [MAG_HI_W-1:0]  mag_hi;
   logic [LAP_SUM_W-1:0] lap_sum;
   logic [LAP_Q_W-1:0]   lap_q;
   logic [SRC_Q_W-1:0]   src_q;

   // two partial products keep each multiplier at most 19 by 31 bits
   always_comb begin
      mag_lo              = in_stage.s4_mag[MAG_LO_W-1:0];
      mag_hi              = in_stage.s4_mag[MAG_W-1:MAG_LO_W];
      prod_in.lap_neg     = in_stage.s4_neg;
      prod_in.lap_lo_prod = mag_lo * cfg.inv_spacing_sq;
      prod_in.lap_hi_prod = mag_hi * cfg.inv_spacing_sq;
      prod_in.src_prod    = in_stage.source_strength * cfg.inv_burn_duration;
      prod_in.centre_temp  = in_stage.centre_temp;
      prod_in.new_deadline = in_stage.new_deadline;
      prod_in.source_on    = in_stage.source_on;
   end

   always_comb begin
      lap_sum = {prod_ff.lap_hi_prod, {MAG_LO_W{1'b0}}}
              + {{(LAP_SUM_W-LO_PROD_W){1'b0}}, prod_ff.lap_lo_prod};
      lap_q   = lap_sum[LAP_SUM_W-1:LAP_SHIFT];
      if (prod_ff.lap_neg) begin
         if ((|lap_q[LAP_Q_W-1:TEMP_W]) || (lap_q[TEMP_W-1] && (|lap_q[TEMP_W-2:0]))) begin
            scaled_in.laplacian = TEMP_FLOOR;
         end else begin
            scaled_in.laplacian = -lap_q[TEMP_W-1:0];
         end
      end else begin
         if (|lap_q[LAP_Q_W-1:TEMP_W-1]) begin
            scaled_in.laplacian = TEMP_CEIL;
         end else begin
            scaled_in.laplacian = lap_q[TEMP_W-1:0];
         end
      end

      src_q = prod_ff.src_prod[SRC_PROD_W-1:FRAC_W];
      if (!prod_ff.source_on) begin
         scaled_in.source_term = '0;
      end else if (|src_q[SRC_Q_W-1:REG_W]) begin
         scaled_in.source_term = SRC_MAX;
      end else begin
         scaled_in.source_term = src_q[REG_W-1:0];
      end

      scaled_in.centre_temp  = prod_ff.centre_temp;
      scaled_in.new_deadline = prod_ff.new_deadline;
      scaled_in.source_on    = prod_ff.source_on;
   end

   assign scaled_ready    = !scaled_valid_ff || out_ready;
   assign prod_ready      = !prod_valid_ff || scaled_ready;
   assign in_ready        = prod_ready;
   assign prod_valid_in   = prod_ready ? in_valid : prod_valid_ff;
   assign scaled_valid_in = scaled_ready ? prod_valid_ff : scaled_valid_ff;
   assign out_valid       = scaled_valid_ff;
   assign out_stage       = scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff   <= 1'b0;
         scaled_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff   <= prod_valid_in;
         scaled_valid_ff <= scaled_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_ff <= prod_in;
      end
      if (scaled_ready) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule

>>> hdl/dbc_integrate.sv
// stages four to six: heating rate, time step product and saturated new temperature
// depends on dbc_pkg; the last stage is the result register
module dbc_integrate
   import dbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  scaled_type in_stage,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic                rate_valid_ff, rate_valid_in, rate_ready;
   rate_type            rate_ff, rate_in;
   logic                step_valid_ff, step_valid_in, step_ready;
   step_type            step_ff, step_in;
   logic                res_valid_ff, res_valid_in, res_ready;
   result_type          res_ff, res_in;
   logic [TEMP_W:0]     rate_sum;
   logic [TEMP_W-1:0]   rate;
   logic [DELTA_W-1:0]  delta_mag;
   logic [NT_SUM_W-1:0] delta, nt_sum;

   always_comb begin
      rate_sum = {in_stage.laplacian[TEMP_W-1], in_stage.laplacian}
               + {2'b00, in_stage.source_term};
      // the source term is never negative, so only the top can overflow
      rate = (!rate_sum[TEMP_W] && rate_sum[TEMP_W-1]) ? TEMP_CEIL : rate_sum[TEMP_W-1:0];
      rate_in.rate_neg     = rate[TEMP_W-1];
      rate_in.rate_mag     = rate[TEMP_W-1] ? -rate : rate;
      rate_in.laplacian    = in_stage.laplacian;
      rate_in.centre_temp  = in_stage.centre_temp;
      rate_in.new_deadline = in_stage.new_deadline;
      rate_in.source_on    = in_stage.source_on;
   end

   always_comb begin
      step_in.rate_neg     = rate_ff.rate_neg;
      step_in.step_prod    = rate_ff.rate_mag * cfg.time_step;
      step_in.laplacian    = rate_ff.laplacian;
      step_in.centre_temp  = rate_ff.centre_temp;
      step_in.new_deadline = rate_ff.new_deadline;
      step_in.source_on    = rate_ff.source_on;
   end

   always_comb begin
      delta_mag = step_ff.step_prod[STEP_PROD_W-1:FRAC_W];
      delta     = step_ff.rate_neg ? -{2'b00, delta_mag} : {2'b00, delta_mag};
      nt_sum    = {{(NT_SUM_W-TEMP_W){step_ff.centre_temp[TEMP_W-1]}}, step_ff.centre_temp}
                + delta;
      if (!nt_sum[NT_SUM_W-1] && (|nt_sum[NT_SUM_W-2:TEMP_W-1])) begin
         res_in.new_temp = TEMP_CEIL;
      end else if (nt_sum[NT_SUM_W-1] && !(&nt_sum[NT_SUM_W-2:TEMP_W-1])) begin
         res_in.new_temp = TEMP_FLOOR;
      end else begin
         res_in.new_temp = nt_sum[TEMP_W-1:0];
      end
      res_in.laplacian    = step_ff.laplacian;
      res_in.new_deadline = step_ff.new_deadline;
      res_in.source_on    = step_ff.source_on;
   end

   assign res_ready     = !res_valid_ff || out_ready;
   assign step_ready    = !step_valid_ff || res_ready;
   assign rate_ready    = !rate_valid_ff || step_ready;
   assign in_ready      = rate_ready;
   assign rate_valid_in = rate_ready ? in_valid : rate_valid_ff;
   assign step_valid_in = step_ready ? rate_valid_ff : step_valid_ff;
   assign res_valid_in  = res_ready ? step_valid_ff : res_valid_ff;
   assign out_valid     = res_valid_ff;
   assign out_result    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_valid_ff <= 1'b0;
         step_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         rate_valid_ff <= rate_valid_in;
         step_valid_ff <= step_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rate_ready) begin
         rate_ff <= rate_in;
      end
      if (step_ready) begin
         step_ff <= step_in;
      end
      if (res_ready) begin
         res_ff <= res_in;
      end
   end

endmodule

>>> hdl/discrete_burn_cell_update.sv
// top level of the burn cell update block: register file and pipeline wiring
// depends on dbc_pkg, dbc_front, dbc_scale, dbc_integrate and assert_macros.svh
`include "assert_macros.svh"

// Takes one grid cell per clock while req_tready is high and returns one result
// word per cell, in order, through six registered stages: the stencil sum, the
// laplacian and source multipliers, rounding, rate, the time step multiplier
// and the final add. Each stage holds its word while the next one is full, so
// req_tready drops only when all six stages hold words and rsp_tready is low.
// Registers are written through csr_we/csr_addr/csr_wdata and should only be
// changed while no cells are in flight.
module discrete_burn_cell_update
   import dbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // centre, north, south, west, east, northwest, northeast, southwest,
   // southeast temps, burn_deadline, source_strength, current_time
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // new_temp, laplacian, new_deadline, source_on
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cfg_type    cfg_ff, cfg_in;
   cell_type   req_cell;
   front_type  front_stage;
   scaled_type scaled_stage;
   result_type result;
   logic       front_valid, front_ready, scaled_valid, scaled_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_IGNITION_TEMP:     cfg_in.ignition_temp     = csr_wdata;
            CSR_BURN_DURATION:     cfg_in.burn_duration     = csr_wdata;
            CSR_INV_BURN_DURATION: cfg_in.inv_burn_duration = csr_wdata;
            CSR_INV_SPACING_SQ:    cfg_in.inv_spacing_sq    = csr_wdata;
            CSR_TIME_STEP:         cfg_in.time_step         = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ignition_temp     <= IGNITION_TEMP_RST;
         cfg_ff.burn_duration     <= BURN_DURATION_RST;
         cfg_ff.inv_burn_duration <= INV_BURN_DURATION_RST;
         cfg_ff.inv_spacing_sq    <= INV_SPACING_SQ_RST;
         cfg_ff.time_step         <= TIME_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_cell.centre_temp     = req_tdata[31:0];
      req_cell.north_temp      = req_tdata[63:32];
      req_cell.south_temp      = req_tdata[95:64];
      req_cell.west_temp       = req_tdata[127:96];
      req_cell.east_temp       = req_tdata[159:128];
      req_cell.northwest_temp  = req_tdata[191:160];
      req_cell.northeast_temp  = req_tdata[223:192];
      req_cell.southwest_temp  = req_tdata[255:224];
      req_cell.southeast_temp  = req_tdata[287:256];
      req_cell.burn_deadline   = req_tdata[319:288];
      req_cell.source_strength = req_tdata[350:320];
      req_cell.current_time    = req_tdata[381:351];
   end

   dbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cell   (req_cell),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_stage (front_stage)
   );

   dbc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_stage  (front_stage),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_stage (scaled_stage)
   );

   dbc_integrate u_integrate (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (scaled_valid),
      .in_ready   (scaled_ready),
      .in_stage   (scaled_stage),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {7'b0, result.source_on, result.new_deadline,
                       result.laplacian, result.new_temp};

   `DBC_ASSERT_IMPLY(a_on_deadline_live, clock, reset, rsp_tvalid && result.source_on, !result.new_deadline[TEMP_W-1], "burning cell reports a negative deadline")
   `DBC_ASSERT_IMPLY(a_off_deadline_code, clock, reset, rsp_tvalid && !result.source_on, (result.new_deadline == '0) || (result.new_deadline == DEPLETED_MARK), "idle cell reports a deadline other than unburnt or depleted")
   `DBC_ASSERT_IMPLY(a_full_only_when_stalled, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input held off while the result side drains")
   `DBC_ASSERT_NEXT(a_accept_fills_front, clock, reset, req_tvalid && req_tready, front_valid, "accepted cell word missing from the first stage")

endmodule
